### rtl/fsc_pkg.sv
// fsc_pkg: shared types and constants for the flash save command controller
// used by fsc_cmd_seq, the top module and the bench; depends on nothing

package fsc_pkg;

    // command sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_READY         = 8'b0000_0001,
        ST_UNLOCK1       = 8'b0000_0010,
        ST_AWAIT         = 8'b0000_0100,
        ST_ERASE_READY   = 8'b0000_1000,
        ST_ERASE_UNLOCK1 = 8'b0001_0000,
        ST_ERASE_AWAIT   = 8'b0010_0000,
        ST_PROGRAM       = 8'b0100_0000,
        ST_BANK          = 8'b1000_0000
    } t_seq_state;

    // array actions decoded from one write item
    typedef struct packed {
        logic prog;
        logic chip_erase;
        logic sector_erase;
    } t_seq_act;

    // bus access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // command offsets
    localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
    localparam logic [15:0] ADDR_BANK    = 16'h0000;
    localparam logic [15:0] ADDR_ID_MFR  = 16'h0000;
    localparam logic [15:0] ADDR_ID_DEV  = 16'h0001;

    // command bytes
    localparam logic [7:0] BYTE_UNLOCK1  = 8'hAA;
    localparam logic [7:0] BYTE_UNLOCK2  = 8'h55;
    localparam logic [7:0] BYTE_ID_ENTER = 8'h90;
    localparam logic [7:0] BYTE_ID_EXIT  = 8'hF0;
    localparam logic [7:0] BYTE_ERASE    = 8'h80;
    localparam logic [7:0] BYTE_PROGRAM  = 8'hA0;
    localparam logic [7:0] BYTE_BANK     = 8'hB0;
    localparam logic [7:0] BYTE_CHIP_ERS = 8'h10;
    localparam logic [7:0] BYTE_SECT_ERS = 8'h30;

    // chip id bytes
    localparam logic [7:0] ID_MFR_2BANK = 8'h62;
    localparam logic [7:0] ID_MFR_1BANK = 8'h32;
    localparam logic [7:0] ID_DEV_2BANK = 8'h13;
    localparam logic [7:0] ID_DEV_1BANK = 8'h1B;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

### rtl/fsc_flash_ram.sv
// fsc_flash_ram: byte-wide flash array, one write port, one registered read port
// depends on nothing

module fsc_flash_ram #(
    parameter int AW = 17
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [0:(2**AW)-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/fsc_erase_walker.sv
// fsc_erase_walker: address sweep that writes erased bytes over a range
// runs the whole array after reset; depends on nothing

module fsc_erase_walker #(
    parameter int AW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_first,
    input  logic [AW-1:0] i_last,
    output logic          o_busy,
    output logic [AW-1:0] o_wr_addr
);

    logic          r_busy;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_last;
    logic          n_busy;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] n_last;

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        n_last = r_last;
        if (i_start) begin
            n_busy = 1'b1;
            n_addr = i_first;
            n_last = i_last;
        end else if (r_busy) begin
            if (r_addr == r_last) begin
                n_busy = 1'b0;
            end else begin
                n_addr = r_addr + AW'(1);
            end
        end
    end

    // reset starts a sweep over the whole array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
            r_last <= '1;
        end else begin
            r_busy <= n_busy;
            r_addr <= n_addr;
            r_last <= n_last;
        end
    end

    assign o_busy    = r_busy;
    assign o_wr_addr = r_addr;

endmodule

### rtl/fsc_cmd_seq.sv
// fsc_cmd_seq: unlock-sequence command decoder, id mode and bank select
// depends on fsc_pkg

module fsc_cmd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [15:0]       i_addr,
    input  logic [7:0]        i_data,
    input  logic              i_two_banks,
    output fsc_pkg::t_seq_act o_act,
    output logic              o_id_mode,
    output logic              o_bank_sel
);

    fsc_pkg::t_seq_state r_state;
    fsc_pkg::t_seq_state n_state;
    logic                r_id_mode;
    logic                n_id_mode;
    logic                r_bank_sel;
    logic                n_bank_sel;
    fsc_pkg::t_seq_act   act;
    logic                at_unlock1;
    logic                at_unlock2;

    assign at_unlock1 = (i_addr == fsc_pkg::ADDR_UNLOCK1);
    assign at_unlock2 = (i_addr == fsc_pkg::ADDR_UNLOCK2);

    always_comb begin
        n_state    = r_state;
        n_id_mode  = r_id_mode;
        n_bank_sel = r_bank_sel;
        act        = '0;
        if (i_wr) begin
            unique case (r_state)
                fsc_pkg::ST_READY: begin
                    if (at_unlock1 && i_data == fsc_pkg::BYTE_UNLOCK1) begin
                        n_state = fsc_pkg::ST_UNLOCK1;
                    end
                end
                fsc_pkg::ST_UNLOCK1: begin
                    if (at_unlock2 && i_data == fsc_pkg::BYTE_UNLOCK2) begin
                        n_state = fsc_pkg::ST_AWAIT;
                    end
                end
                fsc_pkg::ST_AWAIT: begin
                    if (at_unlock1) begin
                        case (i_data)
                            fsc_pkg::BYTE_ID_ENTER: begin
                                n_id_mode = 1'b1;
                                n_state   = fsc_pkg::ST_READY;
                            end
                            fsc_pkg::BYTE_ID_EXIT: begin
                                n_id_mode = 1'b0;
                                n_state   = fsc_pkg::ST_READY;
                            end
                            fsc_pkg::BYTE_ERASE:   n_state = fsc_pkg::ST_ERASE_READY;
                            fsc_pkg::BYTE_PROGRAM: n_state = fsc_pkg::ST_PROGRAM;
                            fsc_pkg::BYTE_BANK:    n_state = fsc_pkg::ST_BANK;
                            default:               n_state = r_state;
                        endcase
                    end
                end
                fsc_pkg::ST_ERASE_READY: begin
                    if (at_unlock1 && i_data == fsc_pkg::BYTE_UNLOCK1) begin
                        n_state = fsc_pkg::ST_ERASE_UNLOCK1;
                    end
                end
                fsc_pkg::ST_ERASE_UNLOCK1: begin
                    if (at_unlock2 && i_data == fsc_pkg::BYTE_UNLOCK2) begin
                        n_state = fsc_pkg::ST_ERASE_AWAIT;
                    end
                end
                fsc_pkg::ST_ERASE_AWAIT: begin
                    if (i_data == fsc_pkg::BYTE_CHIP_ERS && at_unlock1) begin
                        act.chip_erase = 1'b1;
                        n_state        = fsc_pkg::ST_READY;
                    end else if (i_data == fsc_pkg::BYTE_SECT_ERS) begin
                        act.sector_erase = 1'b1;
                        n_state          = fsc_pkg::ST_READY;
                    end
                end
                fsc_pkg::ST_PROGRAM: begin
                    act.prog = 1'b1;
                    n_state  = fsc_pkg::ST_READY;
                end
                fsc_pkg::ST_BANK: begin
                    if (i_addr == fsc_pkg::ADDR_BANK) begin
                        n_bank_sel = i_data[0] & i_two_banks;
                        n_state    = fsc_pkg::ST_READY;
                    end
                end
                default: begin
                    n_state = fsc_pkg::ST_READY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fsc_pkg::ST_READY;
            r_id_mode  <= 1'b0;
            r_bank_sel <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_id_mode  <= n_id_mode;
            r_bank_sel <= n_bank_sel;
        end
    end

    assign o_act      = act;
    assign o_id_mode  = r_id_mode;
    assign o_bank_sel = r_bank_sel;

endmodule

### rtl/flash_save_command_controller.sv
// flash_save_command_controller: byte-wide flash save memory with command sequencer
// depends on fsc_pkg, fsc_flash_ram, fsc_erase_walker, fsc_cmd_seq

// usage
//   s_axis carries bus accesses: tuser is the kind (read or write), tdata the
//   offset and the byte written. reads give one item on m_axis, writes none.
//   i_cfg_wen/i_cfg_wdata set two_banks (1 = two 64 KiB banks, 0 = one bank);
//   write it only while no access is in flight.
// timing
//   one access is taken per cycle while s_axis_tready is high. a read result
//   goes through the memory stage, then shows on m_axis out of the output register.
//   a chip erase holds s_axis_tready low while it erases every bank present,
//   a sector erase while it erases one sector (SECTOR_BYTES, at most one bank):
//   the erase walker writes one byte a cycle through the single write port.
// reset
//   i_rst_n (synchronous) clears the sequencer, id mode and bank select, sets
//   two_banks, then a clearing pass writes 0xFF over all 2*BANK_BYTES bytes,
//   one a cycle, with s_axis_tready low.
// stall
//   while a read result waits in the output register, one more read can be
//   in the memory stage; beyond that s_axis_tready drops until m_axis moves.
// BANK_BYTES and SECTOR_BYTES are powers of two.

module flash_save_command_controller #(
    parameter int BANK_BYTES   = 65536,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,     // two_banks
    // access stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [15:0] address, [23:16] write_data
    input  logic        s_axis_tuser,    // command: 0 read, 1 write
    // read result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata     // [7:0] read_data
);

    localparam int BANK_AW = $clog2(BANK_BYTES);
    localparam int MEM_AW  = BANK_AW + 1;
    // sector clipped at the bank end
    localparam int SEC_AW  = (SECTOR_BYTES > BANK_BYTES) ? BANK_AW : $clog2(SECTOR_BYTES);
    localparam logic [MEM_AW-1:0] SEC_MASK = MEM_AW'((64'd1 << SEC_AW) - 64'd1);

    // configuration register
    logic r_two_banks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_banks <= 1'b1;
        end else if (i_cfg_wen) begin
            r_two_banks <= i_cfg_wdata;
        end
    end

    // input item fields
    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic        in_accept;
    logic        acc_read;
    logic        acc_write;

    assign in_addr   = s_axis_tdata[15:0];
    assign in_data   = s_axis_tdata[23:16];
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign acc_read  = in_accept & (s_axis_tuser == fsc_pkg::CMD_READ);
    assign acc_write = in_accept & (s_axis_tuser == fsc_pkg::CMD_WRITE);

    // command sequencer
    fsc_pkg::t_seq_act seq_act;
    logic              id_mode;
    logic              bank_sel;

    fsc_cmd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (acc_write),
        .i_addr      (in_addr),
        .i_data      (in_data),
        .i_two_banks (r_two_banks),
        .o_act       (seq_act),
        .o_id_mode   (id_mode),
        .o_bank_sel  (bank_sel)
    );

    // array address of the access: bank bit over the offset within the bank
    logic              bank_used;
    logic [MEM_AW-1:0] arr_addr;

    assign bank_used = bank_sel & r_two_banks;
    assign arr_addr  = {bank_used, in_addr[BANK_AW-1:0]};

    // erase ranges
    logic              erase_start;
    logic [MEM_AW-1:0] erase_first;
    logic [MEM_AW-1:0] erase_last;

    assign erase_start = seq_act.chip_erase | seq_act.sector_erase;

    always_comb begin
        if (seq_act.chip_erase) begin
            erase_first = '0;
            erase_last  = {r_two_banks, {BANK_AW{1'b1}}};
        end else begin
            erase_first = arr_addr & ~SEC_MASK;
            erase_last  = arr_addr | SEC_MASK;
        end
    end

    logic              erase_busy;
    logic [MEM_AW-1:0] erase_addr;

    fsc_erase_walker #(
        .AW (MEM_AW)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (erase_start),
        .i_first   (erase_first),
        .i_last    (erase_last),
        .o_busy    (erase_busy),
        .o_wr_addr (erase_addr)
    );

    // array write port: erase sweep or byte program, never both
    logic              ram_wr_en;
    logic [MEM_AW-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [7:0]        ram_rd_data;

    assign ram_wr_en   = erase_busy | seq_act.prog;
    assign ram_wr_addr = erase_busy ? erase_addr : arr_addr;
    assign ram_wr_data = erase_busy ? fsc_pkg::ERASED_BYTE : in_data;

    fsc_flash_ram #(
        .AW (MEM_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (acc_read),
        .i_rd_addr (arr_addr),
        .o_rd_data (ram_rd_data)
    );

    // chip id byte, picked when the read is taken
    logic       id_hit;
    logic [7:0] id_byte;

    always_comb begin
        id_hit  = 1'b0;
        id_byte = fsc_pkg::ID_MFR_1BANK;
        if (id_mode && in_addr == fsc_pkg::ADDR_ID_MFR) begin
            id_hit  = 1'b1;
            id_byte = r_two_banks ? fsc_pkg::ID_MFR_2BANK : fsc_pkg::ID_MFR_1BANK;
        end else if (id_mode && in_addr == fsc_pkg::ADDR_ID_DEV) begin
            id_hit  = 1'b1;
            id_byte = r_two_banks ? fsc_pkg::ID_DEV_2BANK : fsc_pkg::ID_DEV_1BANK;
        end
    end

    // read in the memory stage, then the output register
    logic       r_rd_pend;
    logic       r_rd_id;
    logic [7:0] r_id_byte;
    logic       r_m_valid;
    logic [7:0] r_m_data;
    logic       n_rd_pend;
    logic       n_m_valid;
    logic       rd_move;

    // pending read moves out once the output register is free
    assign rd_move = r_rd_pend & (~r_m_valid | m_axis_tready);

    // the memory stage must empty this cycle before a new access enters
    assign s_axis_tready = ~erase_busy & (~r_rd_pend | rd_move);

    always_comb begin
        n_rd_pend = r_rd_pend;
        if (acc_read) begin
            n_rd_pend = 1'b1;
        end else if (rd_move) begin
            n_rd_pend = 1'b0;
        end
        n_m_valid = r_m_valid;
        if (rd_move) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_pend <= n_rd_pend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_read) begin
            r_rd_id   <= id_hit;
            r_id_byte <= id_byte;
        end
        if (rd_move) begin
            r_m_data <= r_rd_id ? r_id_byte : ram_rd_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

### tb/sv/flash_save_command_controller_tb.sv
// flash_save_command_controller_tb: self-checking bench for the flash save command controller
// drives bus accesses on s_axis, predicts read bytes in a shadow flash, checks m_axis
// depends on fsc_pkg and flash_save_command_controller

module flash_save_command_controller_tb;

    localparam int BANK_BYTES     = 65536;
    localparam int SECTOR_BYTES   = 4096;
    localparam int ARRAY_BYTES    = 2 * BANK_BYTES;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLD_AFTER_RDS = 60;
    localparam int HOLD_CYCLES    = 150;

    typedef struct packed {
        logic        is_write;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [15:0] address, [23:16] write_data
    logic        s_axis_tuser = 1'b0;   // command: 0 read, 1 write
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] read_data

    flash_save_command_controller #(
        .BANK_BYTES  (BANK_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the chip
    logic [7:0]          flash_mem [ARRAY_BYTES];
    fsc_pkg::t_seq_state seq_state;
    logic                id_on;
    logic                bank_sel;
    logic                mdl_two_banks;

    t_access    pending_accesses [$];
    logic [7:0] expected_bytes [$];
    logic [15:0] hot_addrs [$];

    t_access offered;
    int      src_gap = 0;
    int      rx_gap = 0;
    int      hold_left = 0;
    logic    hold_done = 1'b0;
    int      reads_taken = 0;
    logic    last_phase = 1'b0;
    logic    tail_quiet = 1'b0;
    int      err_count = 0;
    int      cycle_count = 0;
    int      run_items;
    int      sector_budget = 20;
    logic [7:0] want;

    // bus access applied to the shadow chip; reads queue the byte they must return
    function automatic void flash_apply(input t_access acc);
        int unsigned base;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        logic [7:0]  rd;
        base = (bank_sel & mdl_two_banks) ? BANK_BYTES : 0;
        if (acc.is_write == fsc_pkg::CMD_READ) begin
            if (id_on && acc.addr == fsc_pkg::ADDR_ID_MFR) begin
                rd = mdl_two_banks ? fsc_pkg::ID_MFR_2BANK : fsc_pkg::ID_MFR_1BANK;
            end else if (id_on && acc.addr == fsc_pkg::ADDR_ID_DEV) begin
                rd = mdl_two_banks ? fsc_pkg::ID_DEV_2BANK : fsc_pkg::ID_DEV_1BANK;
            end else begin
                rd = flash_mem[base + acc.addr % BANK_BYTES];
            end
            expected_bytes.push_back(rd);
            return;
        end
        case (seq_state)
            fsc_pkg::ST_READY: begin
                if (acc.addr == fsc_pkg::ADDR_UNLOCK1 &&
                    acc.wdata == fsc_pkg::BYTE_UNLOCK1) begin
                    seq_state = fsc_pkg::ST_UNLOCK1;
                end
            end
            fsc_pkg::ST_UNLOCK1: begin
                if (acc.addr == fsc_pkg::ADDR_UNLOCK2 &&
                    acc.wdata == fsc_pkg::BYTE_UNLOCK2) begin
                    seq_state = fsc_pkg::ST_AWAIT;
                end
            end
            fsc_pkg::ST_AWAIT: begin
                if (acc.addr == fsc_pkg::ADDR_UNLOCK1) begin
                    case (acc.wdata)
                        fsc_pkg::BYTE_ID_ENTER: begin
                            id_on = 1'b1;
                            seq_state = fsc_pkg::ST_READY;
                        end
                        fsc_pkg::BYTE_ID_EXIT: begin
                            id_on = 1'b0;
                            seq_state = fsc_pkg::ST_READY;
                        end
                        fsc_pkg::BYTE_ERASE:   seq_state = fsc_pkg::ST_ERASE_READY;
                        fsc_pkg::BYTE_PROGRAM: seq_state = fsc_pkg::ST_PROGRAM;
                        fsc_pkg::BYTE_BANK:    seq_state = fsc_pkg::ST_BANK;
                        default:               ;
                    endcase
                end
            end
            fsc_pkg::ST_ERASE_READY: begin
                if (acc.addr == fsc_pkg::ADDR_UNLOCK1 &&
                    acc.wdata == fsc_pkg::BYTE_UNLOCK1) begin
                    seq_state = fsc_pkg::ST_ERASE_UNLOCK1;
                end
            end
            fsc_pkg::ST_ERASE_UNLOCK1: begin
                if (acc.addr == fsc_pkg::ADDR_UNLOCK2 &&
                    acc.wdata == fsc_pkg::BYTE_UNLOCK2) begin
                    seq_state = fsc_pkg::ST_ERASE_AWAIT;
                end
            end
            fsc_pkg::ST_ERASE_AWAIT: begin
                if (acc.wdata == fsc_pkg::BYTE_CHIP_ERS) begin
                    // chip erase only counts at the command offset
                    if (acc.addr == fsc_pkg::ADDR_UNLOCK1) begin
                        span = mdl_two_banks ? ARRAY_BYTES : BANK_BYTES;
                        for (int unsigned i = 0; i < span; i++) begin
                            flash_mem[i] = fsc_pkg::ERASED_BYTE;
                        end
                        seq_state = fsc_pkg::ST_READY;
                    end
                end else if (acc.wdata == fsc_pkg::BYTE_SECT_ERS) begin
                    lo = ((acc.addr % BANK_BYTES) / SECTOR_BYTES) * SECTOR_BYTES;
                    hi = lo + SECTOR_BYTES;
                    if (hi > BANK_BYTES) hi = BANK_BYTES;
                    for (int unsigned i = lo; i < hi; i++) begin
                        flash_mem[base + i] = fsc_pkg::ERASED_BYTE;
                    end
                    seq_state = fsc_pkg::ST_READY;
                end
            end
            fsc_pkg::ST_PROGRAM: begin
                flash_mem[base + acc.addr % BANK_BYTES] = acc.wdata;
                seq_state = fsc_pkg::ST_READY;
            end
            fsc_pkg::ST_BANK: begin
                if (acc.addr == fsc_pkg::ADDR_BANK) begin
                    bank_sel = acc.wdata[0] & mdl_two_banks;
                    seq_state = fsc_pkg::ST_READY;
                end
            end
            default: seq_state = fsc_pkg::ST_READY;
        endcase
    endfunction

    // sender: offers queued accesses, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                flash_apply(offered);
                if (offered.is_write == fsc_pkg::CMD_READ) reads_taken <= reads_taken + 1;
            end
            tail_quiet <= last_phase && pending_accesses.size() < 80;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    offered = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {offered.wdata, offered.addr};
                    s_axis_tuser <= offered.is_write;
                    if (!tail_quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 5);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off once enough reads went in, so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reads_taken >= HOLD_AFTER_RDS) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: checks every read byte against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: read_data with no read pending: expected none, actual %02h",
                             $time, m_axis_tdata);
                    err_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: read_data mismatch: expected %02h, actual %02h",
                                 $time, want, m_axis_tdata);
                        err_count++;
                    end
                end
            end
            if (rx_gap != 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!tail_quiet && $urandom_range(0, 4) == 0) rx_gap = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("flash_save_command_controller verification failed");
            $finish;
        end
    end

    task automatic add_access(input logic is_write, input logic [15:0] addr,
                              input logic [7:0] wdata);
        t_access acc;
        acc.is_write = is_write;
        acc.addr = addr;
        acc.wdata = wdata;
        pending_accesses.push_back(acc);
    endtask

    task automatic add_unlock();
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK1, fsc_pkg::BYTE_UNLOCK1);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK2, fsc_pkg::BYTE_UNLOCK2);
    endtask

    task automatic add_command(input logic [7:0] code);
        add_unlock();
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK1, code);
    endtask

    function automatic logic [15:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && hot_addrs.size() != 0) begin
            return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
        end
        if (sel == 4) return 16'($urandom_range(0, 1));
        if (sel == 5) return 16'h7000 + 16'($urandom_range(0, 255));
        if (sel == 6) return $urandom_range(0, 1) ? fsc_pkg::ADDR_UNLOCK1 : 16'hFFFF;
        return 16'($urandom);
    endfunction

    // one random stretch: mostly well-formed command sequences with random content
    task automatic add_random_run();
        int          pick;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            add_access(fsc_pkg::CMD_READ, pick_addr(), 8'($urandom));
            run_items += 1;
        end else if (pick < 60 || (pick >= 76 && pick < 80 && sector_budget == 0)) begin
            a = pick_addr();
            add_command(fsc_pkg::BYTE_PROGRAM);
            add_access(fsc_pkg::CMD_WRITE, a, 8'($urandom));
            hot_addrs.push_back(a);
            if (hot_addrs.size() > 24) void'(hot_addrs.pop_front());
            run_items += 4;
        end else if (pick < 68) begin
            add_command($urandom_range(0, 1) ? fsc_pkg::BYTE_ID_ENTER
                                             : fsc_pkg::BYTE_ID_EXIT);
            add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_MFR, 8'($urandom));
            add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_DEV, 8'($urandom));
            run_items += 5;
        end else if (pick < 76) begin
            add_command(fsc_pkg::BYTE_BANK);
            // a write off the bank offset is ignored, the sequencer keeps waiting
            if ($urandom_range(0, 2) == 0) begin
                add_access(fsc_pkg::CMD_WRITE, 16'($urandom_range(1, 65535)), 8'($urandom));
                run_items += 1;
            end
            add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_BANK, 8'($urandom));
            run_items += 4;
        end else if (pick < 80) begin
            sector_budget--;
            add_command(fsc_pkg::BYTE_ERASE);
            add_unlock();
            add_access(fsc_pkg::CMD_WRITE, pick_addr(), fsc_pkg::BYTE_SECT_ERS);
            run_items += 6;
        end else if (pick < 90) begin
            // broken sequences
            case ($urandom_range(0, 3))
                0: begin
                    add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK1, fsc_pkg::BYTE_UNLOCK1);
                    add_access(fsc_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
                    run_items += 2;
                end
                1: begin
                    add_unlock();
                    add_access(fsc_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
                    run_items += 3;
                end
                2: begin
                    add_command(fsc_pkg::BYTE_ERASE);
                    add_access(fsc_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
                    run_items += 4;
                end
                default: begin
                    add_command(8'($urandom));
                    run_items += 3;
                end
            endcase
        end else begin
            add_access(fsc_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
            run_items += 1;
        end
    endtask

    task automatic add_random(input int target);
        run_items = 0;
        while (run_items < target) add_random_run();
        // a closing read cannot pass until any erase has finished
        add_access(fsc_pkg::CMD_READ, 16'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_accesses.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_two_banks(input logic value);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= value;
        mdl_two_banks = value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic add_chip_erase();
        add_command(fsc_pkg::BYTE_ERASE);
        add_unlock();
        // wrong offset, ignored
        add_access(fsc_pkg::CMD_WRITE, 16'h1000, fsc_pkg::BYTE_CHIP_ERS);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK1, fsc_pkg::BYTE_CHIP_ERS);
        add_access(fsc_pkg::CMD_READ, 16'hFFFF, 8'h00);
    endtask

    initial begin
        for (int i = 0; i < ARRAY_BYTES; i++) flash_mem[i] = fsc_pkg::ERASED_BYTE;
        seq_state = fsc_pkg::ST_READY;
        id_on = 1'b0;
        bank_sel = 1'b0;
        mdl_two_banks = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // two banks: field extremes, id mode, program, bank select, sector erase
        set_two_banks(1'b1);
        add_access(fsc_pkg::CMD_READ, 16'h0000, 8'hFF);
        add_access(fsc_pkg::CMD_READ, 16'hFFFF, 8'h00);
        add_command(fsc_pkg::BYTE_PROGRAM);
        add_access(fsc_pkg::CMD_WRITE, 16'hFFFF, 8'h00);
        add_access(fsc_pkg::CMD_READ, 16'hFFFF, 8'hFF);
        add_command(fsc_pkg::BYTE_ID_ENTER);
        add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_MFR, 8'h00);
        add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_DEV, 8'h00);
        add_command(fsc_pkg::BYTE_ID_EXIT);
        add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_MFR, 8'h00);
        add_command(fsc_pkg::BYTE_BANK);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_BANK, 8'hFF);
        add_access(fsc_pkg::CMD_READ, 16'hFFFF, 8'h00);
        // wrong offset in the unlock pair is ignored
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK1, fsc_pkg::BYTE_UNLOCK1);
        add_access(fsc_pkg::CMD_WRITE, 16'h1234, fsc_pkg::BYTE_UNLOCK2);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK2, fsc_pkg::BYTE_UNLOCK2);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_UNLOCK1, fsc_pkg::BYTE_ERASE);
        add_unlock();
        add_access(fsc_pkg::CMD_WRITE, 16'h7777, fsc_pkg::BYTE_SECT_ERS);
        add_random(220);
        wait_idle();

        // one bank: id bytes change, bank select forced to 0, chip erase of one bank
        set_two_banks(1'b0);
        add_command(fsc_pkg::BYTE_ID_ENTER);
        add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_MFR, 8'h00);
        add_access(fsc_pkg::CMD_READ, fsc_pkg::ADDR_ID_DEV, 8'h00);
        add_command(fsc_pkg::BYTE_ID_EXIT);
        add_command(fsc_pkg::BYTE_BANK);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_BANK, 8'h01);
        add_chip_erase();
        add_random(130);
        wait_idle();

        // back to two banks, chip erase of both, then random with a quiet tail
        set_two_banks(1'b1);
        last_phase = 1'b1;
        add_chip_erase();
        add_command(fsc_pkg::BYTE_BANK);
        add_access(fsc_pkg::CMD_WRITE, fsc_pkg::ADDR_BANK, 8'h01);
        add_random(190);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("flash_save_command_controller verification clean");
        end else begin
            $display("flash_save_command_controller verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/fsc_pkg.sv
rtl/fsc_flash_ram.sv
rtl/fsc_erase_walker.sv
rtl/fsc_cmd_seq.sv
rtl/flash_save_command_controller.sv
tb/sv/flash_save_command_controller_tb.sv
